@@ design/mrs_pkg.sv @@
package mrs_pkg;

  localparam int COORD_BITS = 32;
  localparam int INDEX_BITS = 24;
  localparam int COUNT_BITS = INDEX_BITS + 1;

  localparam logic [3:0] DIR_RIGHT = 4'b0001;
  localparam logic [3:0] DIR_LEFT  = 4'b0010;
  localparam logic [3:0] DIR_UP    = 4'b0100;
  localparam logic [3:0] DIR_DOWN  = 4'b1000;
  localparam logic [3:0] DIR_ALL   = 4'b1111;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {1'b1, {INDEX_BITS{1'b0}}};

  // output queue, depth a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QFILL_BITS  = QPTR_BITS + 1;

  // one emitted run
  typedef struct packed {
    logic [INDEX_BITS-1:0]        start;
    logic [COUNT_BITS-1:0]        count;
    logic [3:0]                   dir;
    logic signed [COORD_BITS-1:0] x_min;
    logic signed [COORD_BITS-1:0] x_max;
    logic signed [COORD_BITS-1:0] y_min;
    logic signed [COORD_BITS-1:0] y_max;
    logic                         last;
  } run_t;

  // no run open
  localparam run_t RUN_IDLE = '{dir: DIR_ALL, default: '0};

  // what the segmenter hands to the output queue in one cycle
  typedef struct packed {
    logic [1:0] num;
    run_t       first;
    run_t       second;
  } push_t;

endpackage

@@ design/monotone_run_segmenter_unit.sv @@
// Splits a point stream into runs monotone in at least one direction and emits
// one word per finished run (start, count, direction mask, bounding box). A
// point is taken every cycle while the four-word output queue has two free
// slots; a point yields zero, one or two words, so the sustained rate is one
// point per cycle unless the consumer stalls or points yield two words, in
// which case the single output port (one word per cycle) sets the pace. An
// emitted word appears on the output at the earliest the cycle after its point
// is taken, later when older words are still queued ahead of it.
module monotone_run_segmenter_unit import mrs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [INDEX_BITS-1:0]        point_index_i,
  input  logic                         flush_after_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [INDEX_BITS-1:0]        run_start_o,
  output logic [COUNT_BITS-1:0]        run_count_o,
  output logic [3:0]                   dir_mask_o,
  output logic signed [COORD_BITS-1:0] box_x_min_o,
  output logic signed [COORD_BITS-1:0] box_x_max_o,
  output logic signed [COORD_BITS-1:0] box_y_min_o,
  output logic signed [COORD_BITS-1:0] box_y_max_o,
  output logic                         last_of_run_o
);

  push_t push;
  run_t  head;
  logic  room;
  logic  take;

  assign in_ready_o = room;
  assign take       = in_valid_i && room;

  mrs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_index_i (point_index_i),
    .flush_after_i (flush_after_i),
    .push_o        (push)
  );

  mrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign run_start_o   = head.start;
  assign run_count_o   = head.count;
  assign dir_mask_o    = head.dir;
  assign box_x_min_o   = head.x_min;
  assign box_x_max_o   = head.x_max;
  assign box_y_min_o   = head.y_min;
  assign box_y_max_o   = head.y_max;
  assign last_of_run_o = head.last;

endmodule

@@ design/mrs_core.sv @@
module mrs_core import mrs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [INDEX_BITS-1:0]        point_index_i,
  input  logic                         flush_after_i,
  output push_t                        push_o
);

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic [INDEX_BITS-1:0]        prev_index_q;
  run_t                         run_q, run_d;
  run_t                         base, grown, old_run;
  logic                         open, split;
  logic [3:0]                   holds, nd;

  assign open = (run_q.count != '0);

  always_comb begin
    holds = '0;
    if (point_x_i >= prev_x_q) holds = holds | DIR_RIGHT;
    if (point_x_i <= prev_x_q) holds = holds | DIR_LEFT;
    if (point_y_i >= prev_y_q) holds = holds | DIR_UP;
    if (point_y_i <= prev_y_q) holds = holds | DIR_DOWN;
  end

  assign nd    = run_q.dir & holds;
  assign split = open && (nd == 4'b0000);

  always_comb begin
    old_run      = run_q;
    old_run.last = ~flush_after_i;

    base = run_q;
    if (!open) begin
      base.start = point_index_i;
      base.count = COUNT_BITS'(1);
      base.dir   = DIR_ALL;
      base.x_min = point_x_i;
      base.x_max = point_x_i;
      base.y_min = point_y_i;
      base.y_max = point_y_i;
    end else if (split) begin
      // new run restarts from the previous point, which both runs share
      base.start = prev_index_q;
      base.count = COUNT_BITS'(1);
      base.dir   = holds;
      base.x_min = prev_x_q;
      base.x_max = prev_x_q;
      base.y_min = prev_y_q;
      base.y_max = prev_y_q;
    end else begin
      base.dir = nd;
    end
    base.last = 1'b1;

    grown = base;
    if (open) begin
      if (point_x_i < base.x_min) grown.x_min = point_x_i;
      if (point_x_i > base.x_max) grown.x_max = point_x_i;
      if (point_y_i < base.y_min) grown.y_min = point_y_i;
      if (point_y_i > base.y_max) grown.y_max = point_y_i;
      if (base.count < COUNT_MAX) grown.count = base.count + COUNT_BITS'(1);
    end

    run_d = grown;
    if (flush_after_i) begin
      run_d       = '0;
      run_d.dir   = DIR_ALL;
    end
  end

  always_comb begin
    push_o.num    = 2'(split) + 2'(flush_after_i);
    push_o.first  = split ? old_run : grown;
    push_o.second = grown;
    if (!take_i) push_o.num = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_index_q <= '0;
      run_q        <= RUN_IDLE;
    end else if (take_i) begin
      prev_x_q     <= point_x_i;
      prev_y_q     <= point_y_i;
      prev_index_q <= point_index_i;
      run_q        <= run_d;
    end
  end

endmodule

@@ design/mrs_queue.sv @@
module mrs_queue import mrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output run_t  head_o
);

  run_t                  slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_q, rd_q;
  logic [QFILL_BITS-1:0] fill_q;
  logic                  pop;

  assign valid_o = (fill_q != '0);
  assign head_o  = slot_q[rd_q];
  assign pop     = valid_o && ready_i;
  // two free slots whatever happens this cycle
  assign room_o  = (fill_q <= QFILL_BITS'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) slot_q[wr_q] <= push_i.first;
    if (push_i.num == 2'd2) slot_q[wr_q + QPTR_BITS'(1)] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_q + QPTR_BITS'(push_i.num);
      rd_q   <= rd_q + QPTR_BITS'(pop);
      fill_q <= fill_q + QFILL_BITS'(push_i.num) - QFILL_BITS'(pop);
    end
  end

endmodule

@@ tb/sv/monotone_run_segmenter_unit_checker.sv @@
`timescale 1ns / 100ps

module monotone_run_segmenter_unit_checker import mrs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [INDEX_BITS-1:0]        point_index_i,
  input  logic                         flush_after_i,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [INDEX_BITS-1:0]        run_start_o,
  input  logic [COUNT_BITS-1:0]        run_count_o,
  input  logic [3:0]                   dir_mask_o,
  input  logic signed [COORD_BITS-1:0] box_x_min_o,
  input  logic signed [COORD_BITS-1:0] box_x_max_o,
  input  logic signed [COORD_BITS-1:0] box_y_min_o,
  input  logic signed [COORD_BITS-1:0] box_y_max_o,
  input  logic                         last_of_run_o,
  output int                           run_errors_o,
  output int                           runs_pending_o
);

  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;
  logic [INDEX_BITS-1:0]        prev_idx;
  run_t                         open_run;
  run_t                         awaited_runs[$];
  int                           mismatches = 0;

  assign run_errors_o = mismatches;

  function automatic run_t seed_run(input logic [INDEX_BITS-1:0] idx,
                                    input logic signed [COORD_BITS-1:0] x,
                                    input logic signed [COORD_BITS-1:0] y);
    run_t r;
    r       = '0;
    r.start = idx;
    r.count = COUNT_BITS'(1);
    r.dir   = DIR_ALL;
    r.x_min = x;
    r.x_max = x;
    r.y_min = y;
    r.y_max = y;
    return r;
  endfunction

  // advances the run state by one point and queues the runs it closes
  task automatic track_point(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic [INDEX_BITS-1:0] idx,
                             input logic flush);
    logic [3:0] holds;
    run_t       closed;
    if (open_run.count == '0) begin
      // nothing open, so no comparison with the stored point
      open_run = seed_run(idx, x, y);
    end else begin
      holds = ((x >= last_x) ? DIR_RIGHT : 4'b0000) | ((x <= last_x) ? DIR_LEFT : 4'b0000) |
              ((y >= last_y) ? DIR_UP : 4'b0000) | ((y <= last_y) ? DIR_DOWN : 4'b0000);
      if ((open_run.dir & holds) == 4'b0000) begin
        closed      = open_run;
        closed.last = !flush;
        awaited_runs.push_back(closed);
        // new run shares the stored point with the one just closed
        open_run     = seed_run(prev_idx, last_x, last_y);
        open_run.dir = holds;
      end else begin
        open_run.dir = open_run.dir & holds;
      end
      if (x < $signed(open_run.x_min)) open_run.x_min = x;
      if (x > $signed(open_run.x_max)) open_run.x_max = x;
      if (y < $signed(open_run.y_min)) open_run.y_min = y;
      if (y > $signed(open_run.y_max)) open_run.y_max = y;
      if (open_run.count != COUNT_MAX) open_run.count = open_run.count + 1'b1;
    end
    last_x   = x;
    last_y   = y;
    prev_idx = idx;
    if (flush) begin
      closed      = open_run;
      closed.last = 1'b1;
      awaited_runs.push_back(closed);
      open_run     = '0;
      open_run.dir = DIR_ALL;
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    run_t want;
    if (!rst_ni) begin
      last_x       = '0;
      last_y       = '0;
      prev_idx     = '0;
      open_run     = '0;
      open_run.dir = DIR_ALL;
      awaited_runs.delete();
      runs_pending_o <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_runs.size() == 0) begin
          $error("run word arrived with no run awaited");
          mismatches++;
        end else begin
          want = awaited_runs.pop_front();
          check_field("run_start", want.start, run_start_o);
          check_field("run_count", want.count, run_count_o);
          check_field("dir_mask", want.dir, dir_mask_o);
          check_field("box_x_min", $signed(want.x_min), box_x_min_o);
          check_field("box_x_max", $signed(want.x_max), box_x_max_o);
          check_field("box_y_min", $signed(want.y_min), box_y_min_o);
          check_field("box_y_max", $signed(want.y_max), box_y_max_o);
          check_field("last_of_run", want.last, last_of_run_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        track_point(point_x_i, point_y_i, point_index_i, flush_after_i);
      end
      runs_pending_o <= awaited_runs.size();
    end
  end

endmodule

@@ tb/sv/monotone_run_segmenter_unit_test.sv @@
`timescale 1ns / 100ps

module monotone_run_segmenter_unit_test;
  import mrs_pkg::*;

  localparam int IDLE_MAX     = 6;
  localparam int POINT_TOTAL  = 1550;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [INDEX_BITS-1:0]        I_MAX = '1;

  typedef enum {SEG_WALK, SEG_NOISE, SEG_CORNER, SEG_DRAIN} seg_kind_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [COORD_BITS-1:0] point_x_i;
  logic signed [COORD_BITS-1:0] point_y_i;
  logic [INDEX_BITS-1:0]        point_index_i;
  logic                         flush_after_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [INDEX_BITS-1:0]        run_start_o;
  logic [COUNT_BITS-1:0]        run_count_o;
  logic [3:0]                   dir_mask_o;
  logic signed [COORD_BITS-1:0] box_x_min_o;
  logic signed [COORD_BITS-1:0] box_x_max_o;
  logic signed [COORD_BITS-1:0] box_y_min_o;
  logic signed [COORD_BITS-1:0] box_y_max_o;
  logic                         last_of_run_o;
  int                           run_errors_o;
  int                           runs_pending_o;

  int                    idle_max = IDLE_MAX;
  int                    points_sent = 0;
  logic [INDEX_BITS-1:0] cur_index = '0;

  monotone_run_segmenter_unit DUT (.*);

  monotone_run_segmenter_unit_checker checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gives up once neither channel has moved a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : sink
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input logic [INDEX_BITS-1:0] idx, input logic flush);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    point_x_i     <= x;
    point_y_i     <= y;
    point_index_i <= idx;
    flush_after_i <= flush;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    points_sent++;
  endtask

  // mostly consecutive indices, with repeats and jumps now and then
  function automatic logic [INDEX_BITS-1:0] next_index();
    int r;
    r = $urandom_range(0, 19);
    if (r == 1) cur_index = INDEX_BITS'($urandom);
    else if (r != 0) cur_index = cur_index + 1'b1;
    return cur_index;
  endfunction

  function automatic int draw_step();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 3));
      1:       return int'($urandom_range(0, 255));
      2:       return int'($urandom_range(0, 1 << 20));
      default: return int'($urandom & 32'h0fff_ffff);
    endcase
  endfunction

  function automatic logic signed [COORD_BITS-1:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return '1;
      default: return COORD_BITS'(1);
    endcase
  endfunction

  initial begin : stimulus
    seg_kind_e                    seg;
    int                           r;
    int                           len;
    int                           sx;
    int                           sy;
    logic                         flush;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    point_x_i     = '0;
    point_y_i     = '0;
    point_index_i = '0;
    flush_after_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first point, ties, splits, flushes and the coordinate extremes
    send_point(0, 0, 0, 1'b0);
    send_point(1, 1, 1, 1'b0);
    send_point(1, 1, 1, 1'b0);
    send_point(1, 5, 2, 1'b0);
    send_point(-5, 3, 3, 1'b0);
    send_point(C_MAX, C_MIN, I_MAX, 1'b0);
    send_point(C_MIN, C_MAX, 7, 1'b1);
    send_point(C_MIN, C_MIN, 0, 1'b1);
    send_point(C_MAX, C_MAX, I_MAX, 1'b0);
    send_point(C_MAX, C_MAX, I_MAX, 1'b1);
    send_point(-1, -1, 100, 1'b0);
    send_point(-2, -1, 50, 1'b0);
    send_point(-3, -2, 51, 1'b0);
    send_point(-3, -2, 52, 1'b0);
    send_point(-2, -3, 53, 1'b1);
    send_point(5, 5, 60, 1'b0);
    send_point(5, 6, 61, 1'b0);
    send_point(5, 4, 62, 1'b0);
    send_point(6, 5, 63, 1'b0);
    send_point(4, 7, 64, 1'b1);
    send_point(C_MIN, 0, 65, 1'b0);
    send_point(C_MAX, 0, 66, 1'b0);
    send_point(C_MIN, C_MIN, 67, 1'b1);

    cur_index = 68;
    px = '0;
    py = '0;
    while (points_sent < POINT_TOTAL) begin
      r = $urandom_range(0, 9);
      if (r < 7) seg = SEG_WALK;
      else if (r == 7) seg = SEG_NOISE;
      else if (r == 8) seg = SEG_CORNER;
      else seg = SEG_DRAIN;
      idle_max = ($urandom_range(0, 6) == 0) ? 0 : IDLE_MAX;

      case (seg)
        SEG_WALK: begin
          // a stretch heading one way, with steps of zero giving ties
          if ($urandom_range(0, 3) == 0) begin
            px = $urandom;
            py = $urandom;
          end
          len = $urandom_range(1, 40);
          sx  = int'($urandom_range(0, 2)) - 1;
          sy  = int'($urandom_range(0, 2)) - 1;
          for (int k = 0; k < len; k++) begin
            px    = px + sx * draw_step();
            py    = py + sy * draw_step();
            flush = ($urandom_range(0, 29) == 0) ||
                    (k == len - 1 && $urandom_range(0, 3) == 0);
            send_point(px, py, next_index(), flush);
          end
        end
        SEG_NOISE: begin
          repeat ($urandom_range(1, 10)) begin
            send_point($urandom, $urandom, INDEX_BITS'($urandom), $urandom_range(0, 3) == 0);
          end
        end
        SEG_CORNER: begin
          repeat ($urandom_range(1, 8)) begin
            send_point(corner_value(), corner_value(), next_index(),
                       $urandom_range(0, 4) == 0);
          end
        end
        default: begin
          // hold the points back until every pending run word is out
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (runs_pending_o != 0) @(posedge clk_i);
        end
      endcase
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (runs_pending_o != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (run_errors_o == 0 && runs_pending_o == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mrs_pkg.sv
design/mrs_core.sv
design/mrs_queue.sv
design/monotone_run_segmenter_unit.sv
tb/sv/monotone_run_segmenter_unit_checker.sv
tb/sv/monotone_run_segmenter_unit_test.sv
